FILE: rtl/drvd_pkg.sv
// Shared types, representation codes and size table for the repcode value decoder.
package drvd_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int CNT_W   = 30;

    localparam logic [4:0] RC_FSINGL = 5'd2;
    localparam logic [4:0] RC_FDOUBL = 5'd7;
    localparam logic [4:0] RC_SSHORT = 5'd12;
    localparam logic [4:0] RC_SNORM  = 5'd13;
    localparam logic [4:0] RC_SLONG  = 5'd14;
    localparam logic [4:0] RC_USHORT = 5'd15;
    localparam logic [4:0] RC_UNORM  = 5'd16;
    localparam logic [4:0] RC_ULONG  = 5'd17;
    localparam logic [4:0] RC_UVARI  = 5'd18;
    localparam logic [4:0] RC_IDENT  = 5'd19;
    localparam logic [4:0] RC_ASCII  = 5'd20;
    localparam logic [4:0] RC_ORIGIN = 5'd22;
    localparam logic [4:0] RC_OBNAME = 5'd23;
    localparam logic [4:0] RC_OBJREF = 5'd24;
    localparam logic [4:0] RC_ATTREF = 5'd25;
    localparam logic [4:0] RC_UNITS  = 5'd27;
    localparam logic [4:0] RC_MAX    = 5'd27;

    localparam logic [15:0] UV2_BIAS = 16'h8000;
    localparam logic [31:0] UV4_BIAS = 32'hC000_0000;

    typedef enum logic [2:0] {
        CLS_DATA,
        CLS_FIXED,
        CLS_UVAR,
        CLS_ALEN,
        CLS_ILEN,
        CLS_BAD_CODE,
        CLS_NO_DECODER
    } t_cls;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FIXED,
        PH_UVAR,
        PH_ALEN,
        PH_ILEN,
        PH_STR
    } t_phase;

    typedef enum logic [2:0] {
        KIND_UNS,
        KIND_SIGNED,
        KIND_F32,
        KIND_F64,
        KIND_LEN,
        KIND_BYTE,
        KIND_NONE
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TRUNC,
        ST_UNKNOWN,
        ST_UNDECODABLE
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       bend;
        t_cls       cls;
        logic [4:0] code;
        logic [4:0] size;
    } t_q_item;

    typedef struct packed {
        logic [63:0] bits;
        t_kind       kind;
        t_status     status;
        logic        last;
    } t_result;

    function automatic logic [4:0] repcode_size(input logic [4:0] code);
        logic [4:0] s;
        case (code)
            5'd1:    s = 5'd2;
            5'd2:    s = 5'd4;
            5'd3:    s = 5'd8;
            5'd4:    s = 5'd12;
            5'd5:    s = 5'd4;
            5'd6:    s = 5'd4;
            5'd7:    s = 5'd8;
            5'd8:    s = 5'd16;
            5'd9:    s = 5'd24;
            5'd10:   s = 5'd8;
            5'd11:   s = 5'd16;
            5'd12:   s = 5'd1;
            5'd13:   s = 5'd2;
            5'd14:   s = 5'd4;
            5'd15:   s = 5'd1;
            5'd16:   s = 5'd2;
            5'd17:   s = 5'd4;
            5'd21:   s = 5'd8;
            5'd26:   s = 5'd1;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/dlis_repcode_value_decoder.sv
// Top level of the RP66 representation-code value decoder.
// A result appears at the output once its final byte has passed through the queue and the output register.
// Throughput: one byte per cycle, sustained while the output side keeps taking items.
// The two-entry queue and the output register absorb stalls on either side.
// Reset is synchronous and active low; it empties the queue and returns the decoder to idle.
module dlis_repcode_value_decoder import drvd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_value_start,
    input  logic [4:0]  i_repcode,
    input  logic        i_buffer_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_value_bits,
    output logic [2:0]  o_value_kind,
    output logic [1:0]  o_status,
    output logic        o_last
);

    t_q_item w_front_item;
    t_q_item w_q_item;
    logic    w_q_full;
    logic    w_q_valid;
    logic    w_pop;
    t_result w_result;

    assign o_in_ready = !w_q_full;

    drvd_front u_front (
        .i_data_byte   (i_data_byte),
        .i_value_start (i_value_start),
        .i_repcode     (i_repcode),
        .i_buffer_end  (i_buffer_end),
        .o_item        (w_front_item)
    );

    drvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !w_q_full),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    drvd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_value_bits = w_result.bits;
    assign o_value_kind = w_result.kind;
    assign o_status     = w_result.status;
    assign o_last       = w_result.last;

endmodule

FILE: rtl/drvd_front.sv
// Front end: classifies the first byte of each value by its representation code and marks other bytes as data.
module drvd_front import drvd_pkg::*; (
    input  logic [7:0] i_data_byte,
    input  logic       i_value_start,
    input  logic [4:0] i_repcode,
    input  logic       i_buffer_end,
    output t_q_item    o_item
);

    t_cls w_cls;

    always_comb begin
        if (!i_value_start) begin
            w_cls = CLS_DATA;
        end else if (i_repcode == 5'd0 || i_repcode > RC_MAX) begin
            w_cls = CLS_BAD_CODE;
        end else if (i_repcode >= RC_OBNAME && i_repcode <= RC_ATTREF) begin
            w_cls = CLS_NO_DECODER;
        end else if (i_repcode == RC_UVARI || i_repcode == RC_ORIGIN) begin
            w_cls = CLS_UVAR;
        end else if (i_repcode == RC_IDENT || i_repcode == RC_UNITS) begin
            w_cls = CLS_ILEN;
        end else if (i_repcode == RC_ASCII) begin
            w_cls = CLS_ALEN;
        end else begin
            w_cls = CLS_FIXED;
        end
    end

    assign o_item.data = i_data_byte;
    assign o_item.bend = i_buffer_end;
    assign o_item.cls  = w_cls;
    assign o_item.code = i_repcode;
    assign o_item.size = repcode_size(i_repcode);

endmodule

FILE: rtl/drvd_queue.sv
// Short register queue between the classifier and the decoding back end.
module drvd_queue import drvd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_q_item o_item
);

    t_q_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_wr_ptr;
    logic [Q_PTR_W-1:0]   n_rd_ptr;
    logic [Q_CNT_W-1:0]   n_count;

    localparam logic [Q_PTR_W-1:0] LAST_PTR = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] FULL_CNT = Q_CNT_W'(Q_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !(i_push && !i_pop))
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Queue read while empty.");

endmodule

FILE: rtl/drvd_back.sv
// Back end: value assembly state machine and registered result stage.
module drvd_back import drvd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_q_item i_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [4:0]         r_code;
    logic [4:0]         n_code;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_target;
    logic [CNT_W-1:0]   n_target;
    logic [63:0]        r_asm;
    logic [63:0]        n_asm;
    logic               r_out_valid;
    t_result            r_result;
    t_result            w_res;
    logic               w_res_valid;

    t_phase             e_phase;
    logic [4:0]         e_code;
    logic [CNT_W-1:0]   e_count;
    logic [CNT_W-1:0]   e_target;
    logic [63:0]        e_asm;
    logic               w_start;
    logic               w_bad_start;

    logic [63:0]        w_sh;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic [CNT_W-1:0]   w_uv_tgt;
    logic               w_uv_done;
    logic [31:0]        w_uv_val;
    logic [31:0]        w_len;
    logic               w_len_zero;
    logic               w_cnt_done;
    logic [7:0]         w_b;
    logic               w_bend;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign w_b         = i_item.data;
    assign w_bend      = i_item.bend;
    assign w_start     = (i_item.cls != CLS_DATA);
    assign w_bad_start = (i_item.cls == CLS_BAD_CODE) || (i_item.cls == CLS_NO_DECODER);

    always_comb begin
        if (w_start) begin
            e_code   = i_item.code;
            e_count  = '0;
            e_target = '0;
            e_asm    = '0;
            case (i_item.cls)
                CLS_FIXED: begin
                    e_phase  = PH_FIXED;
                    e_target = CNT_W'(i_item.size);
                end
                CLS_UVAR: e_phase = PH_UVAR;
                CLS_ALEN: e_phase = PH_ALEN;
                CLS_ILEN: e_phase = PH_ILEN;
                default:  e_phase = PH_IDLE;
            endcase
        end else begin
            e_phase  = r_phase;
            e_code   = r_code;
            e_count  = r_count;
            e_target = r_target;
            e_asm    = r_asm;
        end
    end

    always_comb begin
        w_sh       = {e_asm[55:0], w_b};
        w_cnt_inc  = e_count + 1'b1;
        w_cnt_done = (w_cnt_inc >= e_target);
        if (e_count == '0) begin
            if (!w_b[7]) begin
                w_uv_tgt = CNT_W'(1);
            end else if (!w_b[6]) begin
                w_uv_tgt = CNT_W'(2);
            end else begin
                w_uv_tgt = CNT_W'(4);
            end
        end else begin
            w_uv_tgt = e_target;
        end
        w_uv_done = (w_cnt_inc >= w_uv_tgt);
        if (w_uv_tgt == CNT_W'(1)) begin
            w_uv_val = {24'd0, w_sh[7:0]};
        end else if (w_uv_tgt == CNT_W'(2)) begin
            w_uv_val = {16'd0, w_sh[15:0] - UV2_BIAS};
        end else begin
            w_uv_val = w_sh[31:0] - UV4_BIAS;
        end
        w_len      = (e_phase == PH_ILEN) ? {24'd0, w_b} : w_uv_val;
        w_len_zero = (w_len == 32'd0);
    end

    // Next state of the value assembly.
    always_comb begin
        n_phase  = r_phase;
        n_code   = r_code;
        n_count  = r_count;
        n_target = r_target;
        n_asm    = r_asm;
        if (o_pop) begin
            n_phase  = e_phase;
            n_code   = e_code;
            n_count  = e_count;
            n_target = e_target;
            n_asm    = e_asm;
            unique case (e_phase)
                PH_IDLE: begin
                end
                PH_FIXED: begin
                    n_asm   = w_sh;
                    n_count = w_cnt_inc;
                    if (w_cnt_done || w_bend) begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_UVAR, PH_ALEN: begin
                    n_asm    = w_sh;
                    n_count  = w_cnt_inc;
                    n_target = w_uv_tgt;
                    if (!w_uv_done) begin
                        if (w_bend) begin
                            n_phase = PH_IDLE;
                        end
                    end else if (e_phase == PH_UVAR || w_len_zero || w_bend) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase  = PH_STR;
                        n_count  = '0;
                        n_target = w_len[CNT_W-1:0];
                    end
                end
                PH_ILEN: begin
                    if (w_len_zero || w_bend) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase  = PH_STR;
                        n_count  = '0;
                        n_target = w_len[CNT_W-1:0];
                    end
                end
                PH_STR: begin
                    n_count = w_cnt_inc;
                    if (w_cnt_done || w_bend) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // Result produced by the item being taken from the queue.
    always_comb begin
        w_res_valid   = 1'b0;
        w_res.bits    = '0;
        w_res.kind    = KIND_NONE;
        w_res.status  = ST_OK;
        w_res.last    = 1'b1;
        if (w_start && w_bad_start) begin
            w_res_valid  = 1'b1;
            w_res.status = (i_item.cls == CLS_BAD_CODE) ? ST_UNKNOWN : ST_UNDECODABLE;
        end else begin
            unique case (e_phase)
                PH_IDLE: begin
                end
                PH_FIXED: begin
                    if (w_cnt_done) begin
                        w_res_valid = 1'b1;
                        case (e_code)
                            RC_SSHORT: begin
                                w_res.bits = {{56{w_sh[7]}}, w_sh[7:0]};
                                w_res.kind = KIND_SIGNED;
                            end
                            RC_SNORM: begin
                                w_res.bits = {{48{w_sh[15]}}, w_sh[15:0]};
                                w_res.kind = KIND_SIGNED;
                            end
                            RC_SLONG: begin
                                w_res.bits = {{32{w_sh[31]}}, w_sh[31:0]};
                                w_res.kind = KIND_SIGNED;
                            end
                            RC_USHORT: begin
                                w_res.bits = {56'd0, w_sh[7:0]};
                                w_res.kind = KIND_UNS;
                            end
                            RC_UNORM: begin
                                w_res.bits = {48'd0, w_sh[15:0]};
                                w_res.kind = KIND_UNS;
                            end
                            RC_ULONG: begin
                                w_res.bits = {32'd0, w_sh[31:0]};
                                w_res.kind = KIND_UNS;
                            end
                            RC_FSINGL: begin
                                w_res.bits = {32'd0, w_sh[31:0]};
                                w_res.kind = KIND_F32;
                            end
                            RC_FDOUBL: begin
                                w_res.bits = w_sh;
                                w_res.kind = KIND_F64;
                            end
                            default: begin
                            end
                        endcase
                    end else if (w_bend) begin
                        w_res_valid  = 1'b1;
                        w_res.status = ST_TRUNC;
                    end
                end
                PH_UVAR, PH_ALEN, PH_ILEN: begin
                    if (e_phase != PH_ILEN && !w_uv_done) begin
                        if (w_bend) begin
                            w_res_valid  = 1'b1;
                            w_res.status = ST_TRUNC;
                        end
                    end else if (e_phase == PH_UVAR) begin
                        w_res_valid = 1'b1;
                        w_res.bits  = {32'd0, w_uv_val};
                        w_res.kind  = KIND_UNS;
                    end else if (w_len_zero) begin
                        w_res_valid = 1'b1;
                        w_res.kind  = KIND_LEN;
                    end else if (w_bend) begin
                        w_res_valid  = 1'b1;
                        w_res.status = ST_TRUNC;
                    end else begin
                        w_res_valid = 1'b1;
                        w_res.bits  = {32'd0, w_len};
                        w_res.kind  = KIND_LEN;
                        w_res.last  = 1'b0;
                    end
                end
                PH_STR: begin
                    w_res_valid = 1'b1;
                    if (w_cnt_done) begin
                        w_res.bits = {56'd0, w_b};
                        w_res.kind = KIND_BYTE;
                    end else if (w_bend) begin
                        w_res.status = ST_TRUNC;
                    end else begin
                        w_res.bits = {56'd0, w_b};
                        w_res.kind = KIND_BYTE;
                        w_res.last = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_code      <= '0;
            r_count     <= '0;
            r_target    <= '0;
            r_asm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_count  <= n_count;
            r_target <= n_target;
            r_asm    <= n_asm;
            if (o_pop && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_res_valid) begin
            r_result <= w_res;
        end
    end

    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_res_valid && w_res.last) |=> (r_phase == PH_IDLE))
        else $error("Decoder did not return to idle after the final result.");

    a_fixed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FIXED) |-> (r_count < r_target))
        else $error("Fixed-size value kept open past its size.");

    a_str_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_STR) |-> (r_target != '0) && (r_count < r_target))
        else $error("String state entered with an empty or exhausted length.");

endmodule
